FILE: sv/dpad_autorepeat_button_mapper_defines.svh
// ----------------------------------------------------------------------------
// D-pad mapper assertion macros
// Shared concurrent assertion forms used by the mapper top level.
// ----------------------------------------------------------------------------
`ifndef DPAD_AUTOREPEAT_BUTTON_MAPPER_DEFINES_SVH
`define DPAD_AUTOREPEAT_BUTTON_MAPPER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DPAD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DPAD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/dpad_pkg.sv
// ----------------------------------------------------------------------------
// D-pad mapper package
// Word formats, codes and reset values shared by the mapper modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dpad_pkg;

  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 32;
  localparam int CODE_W        = 10;
  localparam int MAP_W         = 14;
  localparam int MAP_VALID_BIT = 13;
  localparam int MAP_ACT_LSB   = 10;
  localparam int MAP_REG_COUNT = 4;
  localparam int MAP_BASE      = 4;
  localparam int FIFO_DEPTH    = 2;
  localparam int FIFO_AW       = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

  localparam logic        REQ_EVENT = 1'b0;
  localparam logic        REQ_TICK  = 1'b1;
  localparam logic [4:0]  EV_KEY    = 5'd1;
  localparam logic [4:0]  EV_ABS    = 5'd3;

  localparam logic signed [31:0] THR_LO_RESET   = 32'sd64;
  localparam logic signed [31:0] THR_HI_RESET   = 32'sd192;
  localparam logic [15:0]        DELAY_RESET    = 16'd500;
  localparam logic [15:0]        INTERVAL_RESET = 16'd150;
  localparam logic [MAP_W-1:0]   MAP0_RESET     = 14'd8496;
  localparam logic [MAP_W-1:0]   MAP1_RESET     = 14'd9521;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AXIS_LO  = 3'd0,
    REG_AXIS_HI  = 3'd1,
    REG_DELAY    = 3'd2,
    REG_INTERVAL = 3'd3,
    REG_MAP0     = 3'd4,
    REG_MAP1     = 3'd5,
    REG_MAP2     = 3'd6,
    REG_MAP3     = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    ACT_SELECT = 3'd0,
    ACT_CANCEL = 3'd1,
    ACT_BACK   = 3'd2,
    ACT_UP     = 3'd3,
    ACT_DOWN   = 3'd4,
    ACT_LEFT   = 3'd5,
    ACT_RIGHT  = 3'd6,
    ACT_USER   = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    ZONE_CENTRE = 2'd0,
    ZONE_LOW    = 2'd1,
    ZONE_HIGH   = 2'd2
  } zone_t;

  typedef struct packed {
    logic               req_type;
    logic [4:0]         event_type;
    logic [CODE_W-1:0]  event_code;
    logic signed [31:0] event_value;
    logic [31:0]        now_ms;
  } in_word_t;

  typedef struct packed {
    action_t action;
    logic    last;
  } out_word_t;

  typedef struct packed {
    logic    pair;
    action_t act0;
    action_t act1;
  } cmd_t;

  function automatic action_t x_dir(zone_t z);
    return (z == ZONE_LOW) ? ACT_LEFT : ACT_RIGHT;
  endfunction

  function automatic action_t y_dir(zone_t z);
    return (z == ZONE_LOW) ? ACT_UP : ACT_DOWN;
  endfunction

endpackage

`default_nettype wire

FILE: sv/dpad_autorepeat_button_mapper.sv
// ----------------------------------------------------------------------------
// D-pad auto-repeat button mapper
// Input words carry a joystick event or a repeat tick with a millisecond
// timestamp. Output words carry an action code and a flag on the final word
// caused by an input word. Configuration is a write-only register port:
// cfg_we with cfg_index selects the register, cfg_wdata gives its value,
// and writes belong in periods with no word in flight.
// A word is taken on the in_ channel when in_valid is high and in_stall low,
// and delivered on the out_ channel when out_valid is high and out_stall low.
// One input word is taken per cycle while in_stall is low. Its first output
// word is written into the two-entry command queue and then registered in
// the output register before it is offered; a repeat tick that fires both
// axes gives two output words, the second held in the output stage until
// the first is delivered; input words are taken while the queue has room.
// A stalled receiver first fills the queue, then in_stall rises; words held
// in the queue are never dropped. Reset is synchronous: it empties the queue,
// restores register defaults and centres both axes with zero deadlines.
// ----------------------------------------------------------------------------
`default_nettype none
`include "dpad_autorepeat_button_mapper_defines.svh"

module dpad_autorepeat_button_mapper #(
  parameter int MAP_ENTRIES = 4
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [dpad_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [dpad_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic                             in_valid,
  input  wire dpad_pkg::in_word_t               in_word,
  output logic                                  in_stall,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output dpad_pkg::out_word_t                   out_word
);
  import dpad_pkg::*;

  logic push;
  cmd_t push_cmd;
  logic fifo_full;
  logic pop;
  cmd_t pop_cmd;
  logic fifo_empty;

  dpad_front #(
    .MAP_ENTRIES(MAP_ENTRIES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_word   (in_word),
    .in_stall  (in_stall),
    .fifo_full (fifo_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  dpad_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (fifo_full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (fifo_empty)
  );

  dpad_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fifo_empty (fifo_empty),
    .pop_cmd    (pop_cmd),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word)
  );

  `DPAD_ASSERT_SAME(a_no_push_when_full, push, !fifo_full, "command pushed into a full queue")
  `DPAD_ASSERT_SAME(a_no_pop_when_empty, pop, !fifo_empty, "command popped from an empty queue")
  `DPAD_ASSERT_NEXT(a_pair_completes, out_valid && !out_word.last, out_valid, "second word lost")

endmodule

`default_nettype wire

FILE: sv/dpad_front.sv
// ----------------------------------------------------------------------------
// D-pad mapper front end
// Holds configuration and axis state, classifies each input word and queues
// the actions it causes, up to two per input word.
// ----------------------------------------------------------------------------
`default_nettype none

module dpad_front #(
  parameter int MAP_ENTRIES = 4
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [dpad_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [dpad_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic                             in_valid,
  input  wire dpad_pkg::in_word_t               in_word,
  output logic                                  in_stall,
  input  wire logic                             fifo_full,
  output logic                                  push,
  output dpad_pkg::cmd_t                        push_cmd
);
  import dpad_pkg::*;

  localparam int MAP_REGS = (MAP_ENTRIES < MAP_REG_COUNT) ? MAP_ENTRIES : MAP_REG_COUNT;

  logic signed [31:0] lo_thr_r;
  logic signed [31:0] hi_thr_r;
  logic [15:0]        delay_r;
  logic [15:0]        interval_r;
  logic [MAP_W-1:0]   map_r [MAP_REGS];

  zone_t       held_x_r, held_x_nxt;
  zone_t       held_y_r, held_y_nxt;
  logic [31:0] dl_x_r, dl_x_nxt;
  logic [31:0] dl_y_r, dl_y_nxt;

  logic        accept;
  logic        axis_evt;
  logic        key_evt;
  zone_t       zone;
  logic [31:0] diff_x, diff_y;
  logic        x_due, y_due;
  logic [31:0] now_delay, now_interval;
  logic        hit;
  action_t     hit_act;

  assign in_stall = fifo_full;
  assign accept   = in_valid && !fifo_full;

  assign axis_evt = (in_word.req_type == REQ_EVENT) && (in_word.event_type == EV_ABS) &&
                    (in_word.event_code[CODE_W-1:1] == '0);
  assign key_evt  = (in_word.req_type == REQ_EVENT) && (in_word.event_type == EV_KEY) &&
                    (in_word.event_value == 32'sd1);

  assign now_delay    = in_word.now_ms + {16'd0, delay_r};
  assign now_interval = in_word.now_ms + {16'd0, interval_r};
  assign diff_x       = in_word.now_ms - dl_x_r;
  assign diff_y       = in_word.now_ms - dl_y_r;
  assign x_due        = (held_x_r != ZONE_CENTRE) && !diff_x[31];
  assign y_due        = (held_y_r != ZONE_CENTRE) && !diff_y[31];

  always_comb begin
    if (in_word.event_value <= lo_thr_r) begin
      zone = ZONE_LOW;
    end else if (in_word.event_value >= hi_thr_r) begin
      zone = ZONE_HIGH;
    end else begin
      zone = ZONE_CENTRE;
    end
  end

  // The lowest-numbered valid entry wins, so scan from the top down.
  always_comb begin
    hit     = 1'b0;
    hit_act = ACT_SELECT;
    for (int k = MAP_REGS - 1; k >= 0; k--) begin
      if (map_r[k][MAP_VALID_BIT] && (map_r[k][CODE_W-1:0] == in_word.event_code)) begin
        hit     = 1'b1;
        hit_act = action_t'(map_r[k][MAP_ACT_LSB +: 3]);
      end
    end
  end

  always_comb begin
    held_x_nxt = held_x_r;
    held_y_nxt = held_y_r;
    dl_x_nxt   = dl_x_r;
    dl_y_nxt   = dl_y_r;
    push       = 1'b0;
    push_cmd   = '{pair: 1'b0, act0: ACT_SELECT, act1: ACT_SELECT};
    if (accept) begin
      if (in_word.req_type == REQ_TICK) begin
        if (x_due) begin
          dl_x_nxt = now_interval;
        end
        if (y_due) begin
          dl_y_nxt = now_interval;
        end
        push          = x_due || y_due;
        push_cmd.pair = x_due && y_due;
        push_cmd.act0 = x_due ? x_dir(held_x_r) : y_dir(held_y_r);
        push_cmd.act1 = y_dir(held_y_r);
      end else if (axis_evt) begin
        if (!in_word.event_code[0]) begin
          if (zone != held_x_r) begin
            held_x_nxt = zone;
            if (zone != ZONE_CENTRE) begin
              push          = 1'b1;
              push_cmd.act0 = x_dir(zone);
              dl_x_nxt      = now_delay;
            end
          end
        end else begin
          if (zone != held_y_r) begin
            held_y_nxt = zone;
            if (zone != ZONE_CENTRE) begin
              push          = 1'b1;
              push_cmd.act0 = y_dir(zone);
              dl_y_nxt      = now_delay;
            end
          end
        end
      end else if (key_evt && hit) begin
        push          = 1'b1;
        push_cmd.act0 = hit_act;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_thr_r   <= THR_LO_RESET;
      hi_thr_r   <= THR_HI_RESET;
      delay_r    <= DELAY_RESET;
      interval_r <= INTERVAL_RESET;
      for (int k = 0; k < MAP_REGS; k++) begin
        map_r[k] <= (k == 0) ? MAP0_RESET : ((k == 1) ? MAP1_RESET : '0);
      end
      held_x_r <= ZONE_CENTRE;
      held_y_r <= ZONE_CENTRE;
      dl_x_r   <= '0;
      dl_y_r   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_index))
          REG_AXIS_LO:  lo_thr_r   <= cfg_wdata;
          REG_AXIS_HI:  hi_thr_r   <= cfg_wdata;
          REG_DELAY:    delay_r    <= cfg_wdata[15:0];
          REG_INTERVAL: interval_r <= cfg_wdata[15:0];
          default: ;
        endcase
        for (int k = 0; k < MAP_REGS; k++) begin
          if (cfg_index == CFG_IDX_W'(MAP_BASE + k)) begin
            map_r[k] <= cfg_wdata[MAP_W-1:0];
          end
        end
      end
      held_x_r <= held_x_nxt;
      held_y_r <= held_y_nxt;
      dl_x_r   <= dl_x_nxt;
      dl_y_r   <= dl_y_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/dpad_fifo.sv
// ----------------------------------------------------------------------------
// D-pad mapper command queue
// Short queue of action commands between the front end and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module dpad_fifo (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire dpad_pkg::cmd_t  push_cmd,
  output logic                 full,
  input  wire logic            pop,
  output dpad_pkg::cmd_t       pop_cmd,
  output logic                 empty
);
  import dpad_pkg::*;

  cmd_t                mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  wr_ptr_r;
  logic [FIFO_AW-1:0]  rd_ptr_r;
  logic [FIFO_AW:0]    cnt_r;

  assign full    = (cnt_r == (FIFO_AW + 1)'(FIFO_DEPTH));
  assign empty   = (cnt_r == '0);
  assign pop_cmd = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/dpad_back.sv
// ----------------------------------------------------------------------------
// D-pad mapper output stage
// Takes queued commands and presents their actions one word at a time,
// marking the final word of each command.
// ----------------------------------------------------------------------------
`default_nettype none

module dpad_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            fifo_empty,
  input  wire dpad_pkg::cmd_t  pop_cmd,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output dpad_pkg::out_word_t  out_word
);
  import dpad_pkg::*;

  logic      out_valid_r;
  out_word_t out_word_r;
  logic      pend_valid_r;
  action_t   pend_act_r;
  logic      out_take;

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign out_take  = out_valid_r && !out_stall;
  assign pop       = !fifo_empty && (!out_valid_r || (out_take && !pend_valid_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else if (out_take && pend_valid_r) begin
      out_word_r   <= '{action: pend_act_r, last: 1'b1};
      pend_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r  <= 1'b1;
      out_word_r   <= '{action: pop_cmd.act0, last: !pop_cmd.pair};
      pend_valid_r <= pop_cmd.pair;
      pend_act_r   <= pop_cmd.act1;
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule

`default_nettype wire

FILE: tb/dpad_mapper_checker.sv
// ----------------------------------------------------------------------------
// D-pad mapper checker
// Watches the register port and both word channels of the mapper. It keeps
// its own copy of the registers, the held axis zones and the repeat
// deadlines, works out the action words each accepted input word should
// cause, and compares every delivered output word against the oldest one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dpad_mapper_checker #(
  parameter logic [dpad_pkg::CODE_W-1:0] X_AXIS   = 10'd0,
  parameter logic [dpad_pkg::CODE_W-1:0] Y_AXIS   = 10'd1,
  parameter logic signed [31:0]          KEY_DOWN = 32'sd1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [dpad_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dpad_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  dpad_pkg::in_word_t              in_word,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  dpad_pkg::out_word_t             out_word,
  output int                              fail_count,
  output int                              pending_count,
  output int                              checked_count
);
  import dpad_pkg::*;

  localparam int REPORT_LIMIT = 10;

  logic signed [31:0] low_thr;
  logic signed [31:0] high_thr;
  logic [15:0]        delay_ms;
  logic [15:0]        interval_ms;
  logic [MAP_W-1:0]   key_map [MAP_REG_COUNT];
  zone_t              zone_x;
  zone_t              zone_y;
  logic [31:0]        due_x;
  logic [31:0]        due_y;
  out_word_t          pending_actions [$];
  int                 errors = 0;
  int                 checked = 0;
  int                 pending_q = 0;

  assign fail_count    = errors;
  assign pending_count = pending_q;
  assign checked_count = checked;

  function automatic zone_t zone_for(input logic signed [31:0] v);
    if (v <= low_thr) return ZONE_LOW;
    if (v >= high_thr) return ZONE_HIGH;
    return ZONE_CENTRE;
  endfunction

  function automatic logic due_reached(input logic [31:0] now, input logic [31:0] due);
    logic [31:0] diff;
    diff = now - due;
    return !diff[31];
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    action_t   acts [2];
    int        n;
    zone_t     z;
    logic      hit;
    if (!rst_n) begin
      low_thr     = THR_LO_RESET;
      high_thr    = THR_HI_RESET;
      delay_ms    = DELAY_RESET;
      interval_ms = INTERVAL_RESET;
      key_map[0]  = MAP0_RESET;
      key_map[1]  = MAP1_RESET;
      key_map[2]  = '0;
      key_map[3]  = '0;
      zone_x      = ZONE_CENTRE;
      zone_y      = ZONE_CENTRE;
      due_x       = '0;
      due_y       = '0;
      pending_actions.delete();
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_AXIS_LO:  low_thr = cfg_wdata;
          REG_AXIS_HI:  high_thr = cfg_wdata;
          REG_DELAY:    delay_ms = cfg_wdata[15:0];
          REG_INTERVAL: interval_ms = cfg_wdata[15:0];
          default:      key_map[2'(cfg_index - MAP_BASE)] = cfg_wdata[MAP_W-1:0];
        endcase
      end

      if (out_valid && !out_stall) begin
        checked++;
        if (pending_actions.size() == 0) begin
          if (errors < REPORT_LIMIT)
            $display("Unexpected word: action %0d last %0b with nothing pending",
                     out_word.action, out_word.last);
          errors++;
        end else begin
          want = pending_actions.pop_front();
          if (out_word.action !== want.action || out_word.last !== want.last) begin
            if (errors < REPORT_LIMIT)
              $display("Mismatch: expected action %0d last %0b, got action %0d last %0b",
                       want.action, want.last, out_word.action, out_word.last);
            errors++;
          end
        end
      end

      if (in_valid && !in_stall) begin
        n = 0;
        if (in_word.req_type == REQ_EVENT) begin
          if (in_word.event_type == EV_ABS &&
              (in_word.event_code == X_AXIS || in_word.event_code == Y_AXIS)) begin
            z = zone_for(in_word.event_value);
            if (in_word.event_code == X_AXIS) begin
              if (z != zone_x) begin
                zone_x = z;
                if (z != ZONE_CENTRE) begin
                  acts[n] = (z == ZONE_LOW) ? ACT_LEFT : ACT_RIGHT;
                  n++;
                  due_x = in_word.now_ms + 32'(delay_ms);
                end
              end
            end else begin
              if (z != zone_y) begin
                zone_y = z;
                if (z != ZONE_CENTRE) begin
                  acts[n] = (z == ZONE_LOW) ? ACT_UP : ACT_DOWN;
                  n++;
                  due_y = in_word.now_ms + 32'(delay_ms);
                end
              end
            end
          end else if (in_word.event_type == EV_KEY && in_word.event_value == KEY_DOWN) begin
            // The lowest valid entry with a matching button code wins.
            hit = 1'b0;
            for (int i = 0; i < MAP_REG_COUNT; i++) begin
              if (!hit && key_map[i][MAP_VALID_BIT] &&
                  key_map[i][CODE_W-1:0] == in_word.event_code) begin
                acts[n] = action_t'(key_map[i][MAP_ACT_LSB +: 3]);
                n++;
                hit = 1'b1;
              end
            end
          end
        end else begin
          if (zone_x != ZONE_CENTRE && due_reached(in_word.now_ms, due_x)) begin
            acts[n] = (zone_x == ZONE_LOW) ? ACT_LEFT : ACT_RIGHT;
            n++;
            due_x = in_word.now_ms + 32'(interval_ms);
          end
          if (zone_y != ZONE_CENTRE && due_reached(in_word.now_ms, due_y)) begin
            acts[n] = (zone_y == ZONE_LOW) ? ACT_UP : ACT_DOWN;
            n++;
            due_y = in_word.now_ms + 32'(interval_ms);
          end
        end
        for (int k = 0; k < n; k++) begin
          want.action = acts[k];
          want.last   = (k == n - 1);
          pending_actions.push_back(want);
        end
      end
    end
    pending_q <= pending_actions.size();
  end

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// D-pad mapper testbench
// Drives the mapper with a short directed sequence under the reset register
// values and a hand-picked setting, then with random event streams under six
// further settings, among them extreme thresholds and delays, overlapping
// thresholds and fully random register contents. Both channels idle at
// random, one phase runs without idling and one holds the output off for a
// long stretch. A checker beside the block predicts and compares the words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import dpad_pkg::*;

  localparam logic [CODE_W-1:0]  X_AXIS        = 10'd0;
  localparam logic [CODE_W-1:0]  Y_AXIS        = 10'd1;
  localparam logic signed [31:0] KEY_DOWN      = 32'sd1;
  localparam int                 IDLE_PCT      = 19;
  localparam int                 HOLD_CYCLES   = 300;
  localparam int                 SETTLE_CYCLES = 10;
  localparam int                 RANDOM_ITEMS  = 130;
  localparam int                 PHASES        = 6;
  localparam int                 CYCLE_LIMIT   = 400000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  in_word_t              in_word = '0;
  logic                  in_stall;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_word_t             out_word;

  int fail_count;
  int pending_count;
  int checked_count;
  int cycle_count = 0;
  int words_sent = 0;
  int hold_count = 0;

  logic idle_on = 1'b1;
  logic hold_phase = 1'b0;
  logic hold_used = 1'b0;

  logic signed [31:0] cur_lo;
  logic signed [31:0] cur_hi;
  logic [15:0]        cur_delay;
  logic [15:0]        cur_interval;
  logic [MAP_W-1:0]   cur_map [MAP_REG_COUNT];
  logic [31:0]        clock_ms;

  dpad_autorepeat_button_mapper dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_word   (in_word),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  dpad_mapper_checker #(
    .X_AXIS   (X_AXIS),
    .Y_AXIS   (Y_AXIS),
    .KEY_DOWN (KEY_DOWN)
  ) mapper_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_word       (in_word),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_word      (out_word),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .checked_count (checked_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d words pending", cycle_count, pending_count);
      $display("FAILURE");
      $finish;
    end
  end

  // The receiver holds off once for a long stretch when asked, and otherwise
  // stalls at random while idling is enabled.
  always @(posedge clk) begin
    if (hold_phase && !hold_used) begin
      out_stall  <= 1'b1;
      hold_count <= hold_count + 1;
      if (hold_count == HOLD_CYCLES - 1) hold_used <= 1'b1;
    end else begin
      out_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
    end
  end

  function automatic in_word_t event_word(input logic req, input logic [4:0] etype,
                                          input logic [CODE_W-1:0] code,
                                          input logic [31:0] value, input logic [31:0] now);
    in_word_t w;
    w.req_type    = req;
    w.event_type  = etype;
    w.event_code  = code;
    w.event_value = value;
    w.now_ms      = now;
    return w;
  endfunction

  task automatic send_word(input in_word_t w);
    if (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Unused upper bits of the narrow registers carry random junk.
  task automatic load_settings();
    write_reg(REG_AXIS_LO, cur_lo);
    write_reg(REG_AXIS_HI, cur_hi);
    write_reg(REG_DELAY, {16'($urandom), cur_delay});
    write_reg(REG_INTERVAL, {16'($urandom), cur_interval});
    for (int i = 0; i < MAP_REG_COUNT; i++)
      write_reg(reg_idx_t'(3'(MAP_BASE + i)), {18'($urandom), cur_map[i]});
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    in_word_t w;
    int       n;
    int       pick;
    int       span;
    logic     noise;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset register values: button map lookups, key states other than
    // pressed, axis edges, repeats and deadline wraparound.
    send_word(event_word(REQ_EVENT, EV_KEY, MAP0_RESET[CODE_W-1:0], KEY_DOWN, 32'd10));
    send_word(event_word(REQ_EVENT, EV_KEY, MAP1_RESET[CODE_W-1:0], KEY_DOWN, 32'd20));
    send_word(event_word(REQ_EVENT, EV_KEY, MAP0_RESET[CODE_W-1:0], 32'sd0, 32'd30));
    send_word(event_word(REQ_EVENT, EV_KEY, MAP1_RESET[CODE_W-1:0] + 10'd1, KEY_DOWN,
                         32'd40));
    send_word(event_word(REQ_EVENT, EV_KEY, MAP0_RESET[CODE_W-1:0], 32'sd2, 32'd50));
    send_word(event_word(REQ_EVENT, EV_ABS, X_AXIS, 32'sh8000_0000, 32'd100));
    send_word(event_word(REQ_EVENT, EV_ABS, X_AXIS, 32'sd0, 32'd110));
    send_word(event_word(REQ_TICK, EV_ABS, X_AXIS, 32'sd0, 32'd599));
    send_word(event_word(REQ_TICK, EV_ABS, X_AXIS, 32'sd0, 32'd600));
    send_word(event_word(REQ_EVENT, EV_ABS, Y_AXIS, 32'sh7FFF_FFFF, 32'd700));
    send_word(event_word(REQ_TICK, EV_KEY, Y_AXIS, 32'sd0, 32'd1200));
    send_word(event_word(REQ_EVENT, EV_ABS, X_AXIS, 32'sd128, 32'd1250));
    send_word(event_word(REQ_EVENT, EV_ABS, Y_AXIS + 10'd1, 32'sd0, 32'd1260));
    send_word(event_word(REQ_EVENT, ~EV_KEY, X_AXIS, -32'sd5, 32'd1270));
    send_word(event_word(REQ_EVENT, ~EV_ABS, X_AXIS, KEY_DOWN, 32'd1280));
    send_word(event_word(REQ_EVENT, EV_ABS, X_AXIS, THR_LO_RESET, 32'd1300));
    send_word(event_word(REQ_EVENT, EV_ABS, X_AXIS, THR_HI_RESET, 32'd1310));
    send_word(event_word(REQ_EVENT, EV_ABS, Y_AXIS, THR_LO_RESET, 32'd1320));
    send_word(event_word(REQ_EVENT, EV_ABS, X_AXIS, 32'sh7FFF_FFFF, 32'd1330));
    send_word(event_word(REQ_EVENT, EV_ABS, Y_AXIS, THR_HI_RESET, 32'hFFFF_FF00));
    send_word(event_word(REQ_TICK, EV_ABS, X_AXIS, 32'sd0, 32'hFFFF_FFFF));
    send_word(event_word(REQ_TICK, EV_ABS, X_AXIS, 32'sd0, 32'h0000_00F4));
    drain();

    // Overlapping thresholds, zero delays, a duplicate button code and an
    // entry that is not marked valid.
    cur_lo       = 32'sd100;
    cur_hi       = 32'sd50;
    cur_delay    = '0;
    cur_interval = '0;
    cur_map[0]   = {1'b1, ACT_USER, 10'd7};
    cur_map[1]   = {1'b1, ACT_BACK, 10'd7};
    cur_map[2]   = {1'b0, ACT_UP, 10'd8};
    cur_map[3]   = {1'b1, ACT_RIGHT, 10'h3FF};
    load_settings();
    send_word(event_word(REQ_EVENT, EV_KEY, cur_map[0][CODE_W-1:0], KEY_DOWN, 32'd5000));
    send_word(event_word(REQ_EVENT, EV_KEY, cur_map[2][CODE_W-1:0], KEY_DOWN, 32'd5010));
    send_word(event_word(REQ_EVENT, EV_KEY, cur_map[3][CODE_W-1:0], KEY_DOWN, 32'd5020));
    send_word(event_word(REQ_EVENT, EV_KEY, 10'd0, KEY_DOWN, 32'd5030));
    send_word(event_word(REQ_EVENT, EV_ABS, X_AXIS, 32'sd75, 32'd5040));
    send_word(event_word(REQ_TICK, EV_ABS, X_AXIS, 32'sd0, 32'd5040));
    send_word(event_word(REQ_EVENT, EV_ABS, Y_AXIS, 32'sd75, 32'd5050));
    send_word(event_word(REQ_TICK, EV_ABS, Y_AXIS, 32'sd0, 32'd5050));
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        1: begin
          cur_lo       = 32'sh8000_0000;
          cur_hi       = 32'sh7FFF_FFFF;
          cur_delay    = 16'hFFFF;
          cur_interval = 16'hFFFF;
        end
        2: begin
          cur_lo       = 32'($urandom_range(0, 400)) - 32'd200;
          cur_hi       = cur_lo - 32'($urandom_range(0, 100));
          cur_delay    = '0;
          cur_interval = '0;
        end
        3: begin
          cur_lo       = $urandom;
          cur_hi       = $urandom;
          cur_delay    = 16'($urandom);
          cur_interval = 16'($urandom);
        end
        default: begin
          cur_lo       = 32'($urandom_range(0, 400)) - 32'd200;
          cur_hi       = cur_lo + 32'($urandom_range(1, 300));
          cur_delay    = 16'($urandom_range(0, 600));
          cur_interval = 16'($urandom_range(0, 300));
        end
      endcase
      for (int i = 0; i < MAP_REG_COUNT; i++) begin
        cur_map[i] = MAP_W'($urandom);
        if (p != 3) begin
          cur_map[i][MAP_VALID_BIT] = ($urandom_range(99) < 80);
          if (i > 0 && $urandom_range(2) == 0)
            cur_map[i][CODE_W-1:0] = cur_map[0][CODE_W-1:0];
        end
      end
      load_settings();

      span     = ((cur_delay > cur_interval) ? int'(cur_delay) : int'(cur_interval)) / 2 + 16;
      clock_ms = $urandom;
      idle_on  <= (p != PHASES - 1);
      if (p == PHASES - 2) hold_phase <= 1'b1;

      n = 0;
      while (n < RANDOM_ITEMS) begin
        noise = 1'b0;
        if ($urandom_range(39) == 0) clock_ms = $urandom;
        else clock_ms = clock_ms + 32'($urandom_range(0, span));
        w = event_word(1'($urandom), 5'($urandom), 10'($urandom), $urandom, clock_ms);
        pick = $urandom_range(99);
        if (pick < 35) begin
          w.req_type   = REQ_EVENT;
          w.event_type = EV_ABS;
          w.event_code = $urandom_range(1) ? Y_AXIS : X_AXIS;
          case ($urandom_range(3))
            0: w.event_value = cur_lo + 32'($urandom_range(0, 4)) - 32'd2;
            1: w.event_value = cur_hi + 32'($urandom_range(0, 4)) - 32'd2;
            2: w.event_value = cur_lo / 2 + cur_hi / 2;
            default: ;
          endcase
        end else if (pick < 50) begin
          w.req_type   = REQ_EVENT;
          w.event_type = EV_KEY;
          if ($urandom_range(9) < 7)
            w.event_code = cur_map[$urandom_range(MAP_REG_COUNT - 1)][CODE_W-1:0];
          if ($urandom_range(9) < 8) w.event_value = KEY_DOWN;
          else if ($urandom_range(1) == 0) w.event_value = '0;
        end else if (pick < 85) begin
          w.req_type = REQ_TICK;
        end else begin
          noise = 1'b1;
        end
        send_word(w);
        if (!noise) n++;
      end

      if (p == PHASES - 2) begin
        wait (hold_used);
        hold_phase <= 1'b0;
      end
      drain();
    end

    $display("Sent %0d input words under %0d register settings; checked %0d output words.",
             words_sent, PHASES + 2, checked_count);
    $display("Run included wrapped deadlines, overlapping thresholds, a long output hold-off "
             , "and an idle-free phase.");
    if (fail_count == 0 && pending_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/dpad_pkg.sv
sv/dpad_front.sv
sv/dpad_fifo.sv
sv/dpad_back.sv
sv/dpad_autorepeat_button_mapper.sv
tb/dpad_mapper_checker.sv
tb/tb.sv
